// ===== rtl/core/calt_pkg.sv =====
// ----------------------------------------------------------------------------
// Calorimeter tower accumulator package
// Shared widths, defaults, controller states and the command and status
// structures between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package calt_pkg;

    localparam int PHI_BINS_DEF       = 72;
    localparam int ETA_MAX_OUTER_DEF  = 29;
    localparam int ETA_MAX_FINE_DEF   = 20;
    localparam int ETA_MAX_BARREL_DEF = 17;

    localparam int ETA_W    = 5;
    localparam int PHI_W    = 7;
    localparam int ENERGY_W = 24;
    localparam int ROW_W    = 6;
    localparam int COLR_W   = 7;
    localparam int SUM_W    = 32;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_ZERO_SUPPRESS = REG_IDX_W'(0);

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    localparam logic KIND_HIT  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PREP,
        ST_HIT_RD,
        ST_HIT_WA,
        ST_HIT_WB,
        ST_TWR_RD,
        ST_TWR_OUT
    } t_state;

    typedef struct packed {
        logic                       kind;
        logic [ETA_W-1:0]           eta_abs;
        logic                       eta_positive;
        logic [PHI_W-1:0]           phi_index;
        logic signed [ENERGY_W-1:0] energy;
        logic [ROW_W-1:0]           read_row;
        logic [COLR_W-1:0]          read_col;
    } t_in_item;

    typedef struct packed {
        logic cap;
        logic prep;
        logic rd_en;
        logic rd_b;
        logic wr_acc;
        logic wr_b;
        logic wr_zero;
        logic clr;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic is_read;
        logic any_hit;
        logic need_b;
        logic clr_last;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== rtl/core/calt_if.sv =====
// ----------------------------------------------------------------------------
// Calorimeter tower accumulator channels
// Valid/ready interfaces for the input items and for the tower results.
// ----------------------------------------------------------------------------
`default_nettype none

interface calt_hit_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 kind;
    logic [calt_pkg::ETA_W-1:0]           eta_abs;
    logic                                 eta_positive;
    logic [calt_pkg::PHI_W-1:0]           phi_index;
    logic signed [calt_pkg::ENERGY_W-1:0] energy;
    logic [calt_pkg::ROW_W-1:0]           read_row;
    logic [calt_pkg::COLR_W-1:0]          read_col;

    modport source (
        output valid, kind, eta_abs, eta_positive, phi_index, energy, read_row, read_col,
        input  ready
    );
    modport sink (
        input  valid, kind, eta_abs, eta_positive, phi_index, energy, read_row, read_col,
        output ready
    );
endinterface

interface calt_tower_if;
    logic                              valid;
    logic                              ready;
    logic signed [calt_pkg::SUM_W-1:0] image_energy;
    logic signed [calt_pkg::SUM_W-1:0] barrel_energy;
    logic                              in_barrel;

    modport source (
        output valid, image_energy, barrel_energy, in_barrel,
        input  ready
    );
    modport sink (
        input  valid, image_energy, barrel_energy, in_barrel,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/core/calo_hit_tower_accumulator.sv =====
// ----------------------------------------------------------------------------
// Calorimeter hit tower accumulator
// Accumulates thresholded detector hits into an eta-phi tower map and
// returns towers one at a time, clearing each one as it is read.
//
//   Channel   Direction  Transaction
//   i_hit     in         hit to accumulate, or request to read a tower
//   o_tower   out        tower result, one for each read request
//   APB       in         write or read of the zero_suppress threshold
//
// A hit is captured, prepared, read and written to its first column, then
// to its second in the coarse region when both of its columns lie in the
// map; a dropped hit ends after its read. A read waits out any stall on
// o_tower. The single memory port pair and read-modify-write set this order.
// After reset the map is cleared one tower a cycle, MAP_ROWS * PHI_BINS
// towers (4032 by default), and i_hit is not ready until the pass ends.
// A waiting result on o_tower does not stop hits from being accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module calo_hit_tower_accumulator #(
    parameter int PHI_BINS       = calt_pkg::PHI_BINS_DEF,
    parameter int ETA_MAX_OUTER  = calt_pkg::ETA_MAX_OUTER_DEF,
    parameter int ETA_MAX_FINE   = calt_pkg::ETA_MAX_FINE_DEF,
    parameter int ETA_MAX_BARREL = calt_pkg::ETA_MAX_BARREL_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    calt_hit_if.sink                               i_hit,
    calt_tower_if.source                           o_tower,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [calt_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [calt_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [calt_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                   pready
);
    import calt_pkg::*;

    t_in_item                   item;
    t_dp_cmd                    cmd;
    t_dp_sts                    sts;
    logic                       ready;
    logic                       cfg_sel;
    logic                       cfg_we;
    logic signed [ENERGY_W-1:0] zero_suppress;

    always_comb begin
        item.kind         = i_hit.kind;
        item.eta_abs      = i_hit.eta_abs;
        item.eta_positive = i_hit.eta_positive;
        item.phi_index    = i_hit.phi_index;
        item.energy       = i_hit.energy;
        item.read_row     = i_hit.read_row;
        item.read_col     = i_hit.read_col;
    end

    assign i_hit.ready = ready;

    assign pready  = 1'b1;
    assign cfg_sel = paddr[APB_ADDR_W-1:2] == REG_ZERO_SUPPRESS;
    assign cfg_we  = psel && penable && pwrite && cfg_sel;
    assign prdata  = cfg_sel ? APB_DATA_W'(zero_suppress) : '0;

    calt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_hit.valid),
        .o_ready (ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    calt_dp #(
        .PHI_BINS       (PHI_BINS),
        .ETA_MAX_OUTER  (ETA_MAX_OUTER),
        .ETA_MAX_FINE   (ETA_MAX_FINE),
        .ETA_MAX_BARREL (ETA_MAX_BARREL)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_item          (item),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_cfg_we        (cfg_we),
        .i_cfg_data      (pwdata[ENERGY_W-1:0]),
        .o_zero_suppress (zero_suppress),
        .o_out_valid     (o_tower.valid),
        .i_out_ready     (o_tower.ready),
        .o_image_energy  (o_tower.image_energy),
        .o_barrel_energy (o_tower.barrel_energy),
        .o_in_barrel     (o_tower.in_barrel)
    );

endmodule

`default_nettype wire

// ===== rtl/core/calt_ctrl.sv =====
// ----------------------------------------------------------------------------
// Calorimeter tower accumulator controller
// Sequences the clearing pass, the read-modify-write of hits and the
// read-and-clear of towers.
// ----------------------------------------------------------------------------
`default_nettype none

module calt_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire calt_pkg::t_dp_sts i_sts,
    output calt_pkg::t_dp_cmd      o_cmd
);
    import calt_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (i_sts.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_valid) n_state = ST_PREP;
            end
            ST_PREP: begin
                n_state = i_sts.is_read ? ST_TWR_RD : ST_HIT_RD;
            end
            ST_HIT_RD: begin
                n_state = i_sts.any_hit ? ST_HIT_WA : ST_IDLE;
            end
            ST_HIT_WA: begin
                n_state = i_sts.need_b ? ST_HIT_WB : ST_IDLE;
            end
            ST_HIT_WB: begin
                n_state = ST_IDLE;
            end
            ST_TWR_RD: begin
                n_state = ST_TWR_OUT;
            end
            ST_TWR_OUT: begin
                if (i_sts.out_free) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_ready = 1'b0;
        o_cmd   = '0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr = 1'b1;
            end
            ST_IDLE: begin
                o_ready   = 1'b1;
                o_cmd.cap = i_valid;
            end
            ST_PREP: begin
                o_cmd.prep = 1'b1;
            end
            ST_HIT_RD: begin
                o_cmd.rd_en = 1'b1;
            end
            ST_HIT_WA: begin
                o_cmd.wr_acc = 1'b1;
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_b   = 1'b1;
            end
            ST_HIT_WB: begin
                o_cmd.wr_acc = 1'b1;
                o_cmd.wr_b   = 1'b1;
            end
            ST_TWR_RD: begin
                o_cmd.rd_en = 1'b1;
            end
            ST_TWR_OUT: begin
                o_cmd.out_load = i_sts.out_free;
                o_cmd.wr_zero  = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/calt_dp.sv =====
// ----------------------------------------------------------------------------
// Calorimeter tower accumulator datapath
// Tower map memory, hit placement, saturating accumulation, threshold
// register and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module calt_dp #(
    parameter int PHI_BINS       = calt_pkg::PHI_BINS_DEF,
    parameter int ETA_MAX_OUTER  = calt_pkg::ETA_MAX_OUTER_DEF,
    parameter int ETA_MAX_FINE   = calt_pkg::ETA_MAX_FINE_DEF,
    parameter int ETA_MAX_BARREL = calt_pkg::ETA_MAX_BARREL_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire calt_pkg::t_in_item                    i_item,
    input  wire calt_pkg::t_dp_cmd                     i_cmd,
    output calt_pkg::t_dp_sts                          o_sts,
    input  wire logic                                  i_cfg_we,
    input  wire logic signed [calt_pkg::ENERGY_W-1:0]  i_cfg_data,
    output logic signed [calt_pkg::ENERGY_W-1:0]       o_zero_suppress,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_ready,
    output logic signed [calt_pkg::SUM_W-1:0]          o_image_energy,
    output logic signed [calt_pkg::SUM_W-1:0]          o_barrel_energy,
    output logic                                       o_in_barrel
);
    import calt_pkg::*;

    localparam int MAP_ROWS   = 2 * (ETA_MAX_OUTER - 1);
    localparam int ROW_OFFSET = ETA_MAX_OUTER - 1;
    localparam int MAP_DEPTH  = MAP_ROWS * PHI_BINS;
    localparam int ADDR_W     = $clog2(MAP_DEPTH);
    localparam int BAR_LO     = ROW_OFFSET - ETA_MAX_BARREL;
    localparam int BAR_HI     = ROW_OFFSET + ETA_MAX_BARREL - 1;
    localparam int COL_W      = PHI_W + 2;
    localparam int ROWX_W     = $clog2(2 * ROW_OFFSET + 2 ** ETA_W);

    t_in_item                     r_item;
    logic signed [ENERGY_W-1:0]   r_zs;
    logic signed [ENERGY_W-1:0]   r_addend;
    logic [ADDR_W-1:0]            r_addr_a;
    logic [ADDR_W-1:0]            r_addr_b;
    logic                         r_va;
    logic                         r_vb;
    logic                         r_barrel;
    logic [ADDR_W-1:0]            r_clr_addr;
    logic signed [SUM_W-1:0]      r_mem [MAP_DEPTH];
    logic signed [SUM_W-1:0]      r_rd_data;
    logic                         r_out_valid;
    logic signed [SUM_W-1:0]      r_image;
    logic signed [SUM_W-1:0]      r_barrel_e;
    logic                         r_in_barrel;

    logic [COL_W-1:0]             phi_p;
    logic [COL_W-1:0]             col;
    logic [ROWX_W-1:0]            eta_e;
    logic [ROWX_W-1:0]            row_x;
    logic                         row_ok;
    logic                         keep;
    logic                         coarse;
    logic                         hit_va;
    logic                         hit_vb;
    logic [ADDR_W-1:0]            hit_addr;
    logic [ADDR_W-1:0]            rd_tw_addr;
    logic                         rd_tw_ok;
    logic                         rd_tw_barrel;
    logic [ADDR_W-1:0]            rd_addr;
    logic                         rd_go;
    logic                         mem_we;
    logic [ADDR_W-1:0]            mem_waddr;
    logic signed [SUM_W-1:0]      mem_wdata;
    logic signed [SUM_W:0]        sum_x;
    logic signed [SUM_W-1:0]      sum_sat;
    logic                         out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zs <= '0;
        end else if (i_cfg_we) begin
            r_zs <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_item <= i_item;
        end
    end

    always_comb begin
        phi_p = COL_W'(r_item.phi_index) + COL_W'(2);
        if (phi_p > COL_W'(PHI_BINS)) begin
            phi_p = phi_p - COL_W'(PHI_BINS);
        end
        col = phi_p - COL_W'(1);

        if (int'(r_item.eta_abs) == ETA_MAX_OUTER) begin
            eta_e = ROWX_W'(ETA_MAX_OUTER - 1);
        end else begin
            eta_e = ROWX_W'(r_item.eta_abs);
        end
        row_ok = eta_e <= ROWX_W'(ROW_OFFSET);
        if (r_item.eta_positive) begin
            row_x = ROWX_W'(ROW_OFFSET) + eta_e - ROWX_W'(1);
        end else begin
            row_x = ROWX_W'(ROW_OFFSET) - eta_e;
        end

        keep     = r_item.energy > r_zs;
        coarse   = int'(r_item.eta_abs) > ETA_MAX_FINE;
        hit_va   = keep && row_ok && (col < COL_W'(PHI_BINS));
        hit_vb   = keep && row_ok && coarse && ((col + COL_W'(1)) < COL_W'(PHI_BINS));
        hit_addr = ADDR_W'(row_x) * ADDR_W'(PHI_BINS) + ADDR_W'(col);

        rd_tw_ok     = (int'(r_item.read_row) < MAP_ROWS)
                     && (int'(r_item.read_col) < PHI_BINS);
        rd_tw_barrel = (int'(r_item.read_row) >= BAR_LO)
                     && (int'(r_item.read_row) <= BAR_HI);
        rd_tw_addr   = ADDR_W'(r_item.read_row) * ADDR_W'(PHI_BINS)
                     + ADDR_W'(r_item.read_col);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            if (r_item.kind == KIND_READ) begin
                r_addr_a <= rd_tw_addr;
                r_addr_b <= rd_tw_addr;
                r_va     <= rd_tw_ok;
                r_vb     <= 1'b0;
                r_barrel <= rd_tw_barrel;
            end else begin
                r_addr_a <= hit_addr;
                r_addr_b <= hit_addr + ADDR_W'(1);
                r_va     <= hit_va;
                r_vb     <= hit_vb;
                r_barrel <= 1'b0;
            end
            r_addend <= coarse ? (r_item.energy >>> 1) : r_item.energy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr) begin
            r_clr_addr <= r_clr_addr + ADDR_W'(1);
        end
    end

    always_comb begin
        sum_x = {r_rd_data[SUM_W-1], r_rd_data} + (SUM_W+1)'(r_addend);
        if (sum_x[SUM_W] != sum_x[SUM_W-1]) begin
            sum_sat = sum_x[SUM_W] ? SUM_MIN : SUM_MAX;
        end else begin
            sum_sat = sum_x[SUM_W-1:0];
        end

        rd_addr = i_cmd.rd_b ? r_addr_b : r_addr_a;
        rd_go   = i_cmd.rd_en && (i_cmd.rd_b ? r_vb : r_va);

        mem_we    = 1'b0;
        mem_waddr = r_addr_a;
        mem_wdata = '0;
        if (i_cmd.clr) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
        end else if (i_cmd.wr_zero) begin
            mem_we = r_va;
        end else if (i_cmd.wr_acc) begin
            mem_we    = i_cmd.wr_b ? r_vb : r_va;
            mem_waddr = i_cmd.wr_b ? r_addr_b : r_addr_a;
            mem_wdata = sum_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_go) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_image     <= (r_va && (r_rd_data > SUM_W'(r_zs))) ? r_rd_data : '0;
            r_barrel_e  <= (r_va && r_barrel) ? r_rd_data : '0;
            r_in_barrel <= r_va && r_barrel;
        end
    end

    always_comb begin
        o_sts.is_read  = r_item.kind == KIND_READ;
        o_sts.any_hit  = r_va || r_vb;
        o_sts.need_b   = r_vb;
        o_sts.clr_last = r_clr_addr == ADDR_W'(MAP_DEPTH - 1);
        o_sts.out_free = out_free;
    end

    assign o_zero_suppress = r_zs;
    assign o_out_valid     = r_out_valid;
    assign o_image_energy  = r_image;
    assign o_barrel_energy = r_barrel_e;
    assign o_in_barrel     = r_in_barrel;

endmodule

`default_nettype wire

// ===== rtl/core/calt_checker.sv =====
// ----------------------------------------------------------------------------
// Calorimeter tower accumulator checker
// Port-level properties of the accumulator, attached to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module calt_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              i_in_ready,
    input wire logic                              i_out_valid,
    input wire logic                              i_out_ready,
    input wire logic signed [calt_pkg::SUM_W-1:0] i_image_energy,
    input wire logic signed [calt_pkg::SUM_W-1:0] i_barrel_energy,
    input wire logic                              i_in_barrel
);

    // A result that is held back must not change.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_image_energy)
            && $stable(i_barrel_energy) && $stable(i_in_barrel))
        else $error("stalled tower transaction changed");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_in_barrel |-> i_barrel_energy == '0)
        else $error("barrel energy outside the barrel overlap");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_in_barrel && i_image_energy != '0
            |-> i_image_energy == i_barrel_energy)
        else $error("image and barrel energy disagree");

    // The map is still being cleared just after reset.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !i_in_ready)
        else $error("input ready during the clearing pass");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !i_out_valid)
        else $error("tower transaction offered straight after reset");

endmodule

bind calo_hit_tower_accumulator calt_checker u_calt_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_ready      (i_hit.ready),
    .i_out_valid     (o_tower.valid),
    .i_out_ready     (o_tower.ready),
    .i_image_energy  (o_tower.image_energy),
    .i_barrel_energy (o_tower.barrel_energy),
    .i_in_barrel     (o_tower.in_barrel)
);

`default_nettype wire
